@@ design/tick_task_scheduler_macros.svh @@
// Assertion helpers for the tick task scheduler checker
`ifndef TICK_TASK_SCHEDULER_MACROS_SVH
`define TICK_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define TTS_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tts check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define TTS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tts check failed");

`endif

@@ design/tts_pkg.sv @@
`default_nettype none

package tts_pkg;

    // Table geometry
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // Field widths
    localparam int SLOT_W   = 4;
    localparam int ARR_W    = 16;
    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 10;
    localparam int TIME_W   = 32;
    localparam int POLICY_W = 2;
    localparam int TCOUNT_W = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd1;

    // Scheduling policies
    localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SRTF = 2'd1;
    localparam logic [POLICY_W-1:0] POL_PRIO = 2'd2;

    // Request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic                op;
        logic [SLOT_W-1:0]   slot;
        logic [ARR_W-1:0]    arrival;
        logic [BURST_W-1:0]  burst;
        logic [PRIO_W-1:0]   prio;
    } in_item_t;

    typedef struct packed {
        logic                ran;
        logic [SLOT_W-1:0]   task_res;
        logic [TIME_W-1:0]   tick_time;
        logic                finished;
        logic                all_done;
    } out_item_t;

    // One task table entry as stored in the RAM
    typedef struct packed {
        logic [ARR_W-1:0]    arrival;
        logic [BURST_W-1:0]  remain;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Read issued to the scan unit, one slot per cycle
    typedef struct packed {
        logic                valid;
        logic [IDX_W-1:0]    idx;
        logic                done;
    } scan_req_t;

    // Running winner of the scan
    typedef struct packed {
        logic                busy;
        logic                found;
        logic [IDX_W-1:0]    idx;
        entry_t              entry;
    } scan_best_t;

    // Primary ordering key of an entry under a policy; unused code acts as FCFS
    function automatic logic [ARR_W-1:0] key_of(input entry_t e,
                                                input logic [POLICY_W-1:0] pol);
        logic [ARR_W-1:0] k;
        case (pol)
            POL_SRTF: k = e.remain;
            POL_PRIO: k = ARR_W'(e.prio);
            default:  k = e.arrival;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ design/tts_ram.sv @@
`default_nettype none

module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/tts_scan.sv @@
`default_nettype none

module tts_scan import tts_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                clear,
    input  wire scan_req_t           req,
    input  wire entry_t              rd_entry,
    input  wire logic [POLICY_W-1:0] policy,
    input  wire logic [TIME_W-1:0]   cur_time,
    output scan_best_t               best
);

    scan_req_t        req_d_reg;
    logic             found_reg;
    logic [IDX_W-1:0] idx_reg;
    entry_t           entry_reg;

    logic             eligible;
    logic             better;
    logic [ARR_W-1:0] key_new;
    logic [ARR_W-1:0] key_best;

    // Compare the entry just read against the running winner
    always_comb begin
        key_new  = key_of(rd_entry, policy);
        key_best = key_of(entry_reg, policy);
        eligible = req_d_reg.valid && !req_d_reg.done
                   && (TIME_W'(rd_entry.arrival) <= cur_time);
        better   = !found_reg || (key_new < key_best)
                   || ((key_new == key_best) && (rd_entry.arrival < entry_reg.arrival));
    end

    // Align the request with the RAM read latency and track the winner
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_d_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            req_d_reg <= req;
            if (clear) begin
                found_reg <= 1'b0;
            end else if (eligible && better) begin
                found_reg <= 1'b1;
            end
        end
    end

    // Hold the winner's slot and entry
    always_ff @(posedge aclk) begin
        if (!clear && eligible && better) begin
            idx_reg   <= req_d_reg.idx;
            entry_reg <= rd_entry;
        end
    end

    assign best.busy  = req_d_reg.valid;
    assign best.found = found_reg;
    assign best.idx   = idx_reg;
    assign best.entry = entry_reg;

endmodule

`default_nettype wire

@@ design/tick_task_scheduler.sv @@
// Tick task scheduler: a table of up to MAX_TASKS tasks with one pick per tick.
// Input channel (s_valid/s_ready/s_data) takes one request at a time: a load
// writes one slot of the task table, a tick picks and runs one eligible task.
// Result channel (m_valid/m_ready/m_data) returns exactly one item per request.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; index 0 sets the policy, index 1 the number of slots in use.
// A load writes its slot, a tick with all tasks done goes straight to the
// result, and any other tick scans the slots in use. The scan reads one table
// entry per cycle through the single read port of the task RAM and compares it
// against the running winner; the winner is then written back through the same
// RAM before the result goes to the output register.
// A new request is taken as soon as the previous one has been handed to the
// output register, even while that result still waits for m_ready. If the
// receiver stalls with a result pending, the next finished result waits in
// the block and s_ready stays low until the output register frees up.
// Reset marks every slot done, clears time, policy and task count; the task
// table itself holds no value until a load writes it.
`default_nettype none

module tick_task_scheduler import tts_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    in_item_t             req_reg;
    out_item_t            res_reg;
    out_item_t            m_data_reg;
    logic                 m_valid_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [POLICY_W-1:0]  policy_reg;
    logic [TCOUNT_W-1:0]  count_reg;
    logic [MAX_TASKS-1:0] done_reg;
    logic [CNT_W-1:0]     issue_cnt_reg;

    logic [CNT_W-1:0]     active_n;
    logic                 all_done;
    logic                 accept;
    logic                 emit_fire;
    logic                 slot_ok;
    logic [BURST_W-1:0]   new_rem;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    entry_t               ram_rdata;

    scan_req_t            scan_req;
    scan_best_t           scan_best;
    logic                 scan_clear;

    // Clamp the task count and check whether every active slot is done
    always_comb begin
        active_n = (32'(count_reg) > 32'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                     : CNT_W'(count_reg);
        all_done = 1'b1;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if ((CNT_W'(i) < active_n) && !done_reg[i]) begin
                all_done = 1'b0;
            end
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign emit_fire  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign slot_ok    = (32'(req_reg.slot) < 32'(MAX_TASKS));
    assign scan_clear = accept;
    assign cfg_ready  = 1'b1;

    // Decrement the winner's remaining work, never below zero
    assign new_rem = (scan_best.entry.remain != '0)
                     ? scan_best.entry.remain - BURST_W'(1) : '0;

    // Issue one table read per cycle during the scan
    always_comb begin
        scan_req.valid = (state_reg == ST_SCAN) && (issue_cnt_reg < active_n);
        scan_req.idx   = issue_cnt_reg[IDX_W-1:0];
        scan_req.done  = done_reg[issue_cnt_reg[IDX_W-1:0]];
        ram_raddr      = issue_cnt_reg[IDX_W-1:0];
    end

    // Select the RAM write: a load fills a slot, a run writes back the winner
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(req_reg.slot);
        ram_wdata.arrival = req_reg.arrival;
        ram_wdata.remain  = req_reg.burst;
        ram_wdata.prio    = req_reg.prio;
        if (state_reg == ST_LOAD) begin
            ram_we = slot_ok;
        end else if (state_reg == ST_WRITE) begin
            ram_we    = scan_best.found;
            ram_waddr = scan_best.idx;
            ram_wdata.arrival = scan_best.entry.arrival;
            ram_wdata.remain  = new_rem;
            ram_wdata.prio    = scan_best.entry.prio;
        end
    end

    // Advance the request sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.op == OP_LOAD) begin
                        state_next = ST_LOAD;
                    end else if (all_done) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_LOAD:  state_next = ST_EMIT;
            ST_SCAN: begin
                if (!scan_req.valid && !scan_best.busy) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state: sequencer, done marks, time, configuration, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            done_reg      <= '1;
            time_reg      <= '0;
            policy_reg    <= POL_FCFS;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                issue_cnt_reg <= '0;
            end else if (scan_req.valid) begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            if ((state_reg == ST_LOAD) && slot_ok) begin
                done_reg[IDX_W'(req_reg.slot)] <= (req_reg.burst == '0);
            end
            if (state_reg == ST_WRITE) begin
                if (scan_best.found && (new_rem == '0)) begin
                    done_reg[scan_best.idx] <= 1'b1;
                end
                if (time_reg != '1) begin
                    time_reg <= time_reg + TIME_W'(1);
                end
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_POLICY:     policy_reg <= cfg_data[POLICY_W-1:0];
                    CFG_TASK_COUNT: count_reg  <= cfg_data[TCOUNT_W-1:0];
                    default:        ;
                endcase
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the request, build the result, load the output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg            <= s_data;
            res_reg.ran        <= 1'b0;
            res_reg.task_res   <= '0;
            res_reg.tick_time  <= time_reg;
            res_reg.finished   <= 1'b0;
            res_reg.all_done   <= all_done;
        end
        if ((state_reg == ST_WRITE) && scan_best.found) begin
            res_reg.ran      <= 1'b1;
            res_reg.task_res <= SLOT_W'(scan_best.idx);
            res_reg.finished <= (new_rem == '0);
        end
        if (emit_fire) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    tts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tts_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (scan_clear),
        .req      (scan_req),
        .rd_entry (ram_rdata),
        .policy   (policy_reg),
        .cur_time (time_reg),
        .best     (scan_best)
    );

endmodule

`default_nettype wire

@@ design/tts_checker.sv @@
`default_nettype none
`include "tick_task_scheduler_macros.svh"

module tts_checker import tts_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // A stalled result holds its value
    `TTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // An idle result names no task and finishes nothing
    `TTS_ASSERT_NOW(a_idle_clean, aclk, aresetn, m_valid && !m_data.ran, (m_data.task_res == '0) && !m_data.finished)

    // Nothing runs once every task is done
    `TTS_ASSERT_NOW(a_done_no_run, aclk, aresetn, m_valid && m_data.all_done, !m_data.ran)

    // A valid result after a taken run never goes backward in time
    `TTS_ASSERT_NEXT(a_time_mono, aclk, aresetn, m_valid && m_ready && m_data.ran, !m_valid || (m_data.tick_time >= $past(m_data.tick_time)))

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (.*);

`default_nettype wire
